### sv/sbs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbs_pkg;

   localparam int unsigned MAX_ATTEMPT_LIMIT = 16;

   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam int unsigned REQ_DATA_WIDTH = 24;
   localparam int unsigned REQ_USER_WIDTH = 2;
   localparam int unsigned RSP_DATA_WIDTH = 40;

   localparam logic [4:0]  MAX_ATTEMPTS_RESET = 5'd5;
   localparam logic [15:0] SLOT_TIME_RESET    = 16'd100;

   typedef enum logic [0:0] {
      CSR_MAX_ATTEMPTS = 1'b0,
      CSR_SLOT_TIME    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_REPLY = 2'd1,
      OP_TICK  = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      RC_IDLE    = 3'd0,
      RC_BUSY    = 3'd1,
      RC_HUH     = 3'd2,
      RC_OK      = 3'd3,
      RC_DONE    = 3'd4,
      RC_UNKNOWN = 3'd5,
      RC_CLOSED  = 3'd6
   } reply_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_SENSE   = 3'd1,
      ACT_REQUEST = 3'd2,
      ACT_SUCCESS = 3'd3,
      ACT_GAVE_UP = 3'd4,
      ACT_CLOSED  = 3'd5
   } action_type;

   typedef struct packed {
      logic [4:0]  max_attempts;
      logic [15:0] slot_time;
   } cfg_type;

   typedef struct packed {
      logic [15:0] random_bits;
      logic [2:0]  reply_code;
   } req_data_type;

   typedef struct packed {
      logic [31:0] wait_loaded;
      logic [4:0]  attempt_count;
      logic [2:0]  action;
   } rsp_data_type;

endpackage

`default_nettype wire

### sv/sbs_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module sbs_csr
   import sbs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready,
   output cfg_type                        cfg
);

   logic [4:0]    max_attempts_ff;
   logic [15:0]   slot_time_ff;
   logic          write_en;
   csr_index_type index;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign index      = csr_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_attempts_ff <= MAX_ATTEMPTS_RESET;
         slot_time_ff    <= SLOT_TIME_RESET;
      end else if (write_en) begin
         unique case (index)
            CSR_MAX_ATTEMPTS: max_attempts_ff <= csr_pwdata[4:0];
            CSR_SLOT_TIME:    slot_time_ff    <= csr_pwdata[15:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         CSR_MAX_ATTEMPTS: csr_prdata = {27'b0, max_attempts_ff};
         CSR_SLOT_TIME:    csr_prdata = {16'b0, slot_time_ff};
         default:          csr_prdata = '0;
      endcase
   end

   assign cfg.max_attempts = max_attempts_ff;
   assign cfg.slot_time    = slot_time_ff;

endmodule

`default_nettype wire

### sv/sensing_backoff_sender.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel-sensing sender with binary exponential backoff. Every transaction on
// the req side (start, reply received or one tick) yields exactly one
// transaction on the rsp side: the action to take, the collision count and the
// length of any hold that begins. One transaction is taken per clock cycle
// while rsp_tready does not stall the result register. A transaction is
// captured in an input register when accepted, and its result is loaded into
// the result register once that register can advance, then offered on rsp.
// The state update, including the 16 x 16 multiply that sizes a backoff hold,
// is combinational between those registers. max_attempts (address 0) and
// slot_time (address 4) must be written through the csr port only while no
// transaction is in flight; the block itself does not enforce this.
module sensing_backoff_sender
   import sbs_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   input  wire logic [REQ_DATA_WIDTH-1:0] req_tdata,  // reply_code, random_bits
   input  wire logic [REQ_USER_WIDTH-1:0] req_tuser,  // op
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic      [RSP_DATA_WIDTH-1:0] rsp_tdata,  // action, attempt_count,
                                                      // wait_loaded
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic      [CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                           csr_pready
);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_SENSE = 3'd1,
      PH_REQ   = 3'd2,
      PH_DONE  = 3'd3,
      PH_HOLD  = 3'd4
   } phase_type;

   cfg_type      cfg;
   logic         in_valid_ff;
   req_data_type in_data_ff;
   op_type       in_op_ff;
   logic         rsp_valid_ff;
   rsp_data_type rsp_data_ff;
   rsp_data_type rsp_data_in;
   phase_type    phase_ff, phase_in;
   logic [4:0]   attempts_ff, attempts_in;
   logic [31:0]  wait_left_ff, wait_left_in;
   logic         advance;
   logic         process;
   logic [4:0]   limit;
   logic [4:0]   attempts_inc;
   logic [15:0]  window;
   logic [15:0]  pick;
   logic [31:0]  product;
   logic         product_zero;
   action_type   action;
   logic [31:0]  loaded;
   reply_type    code;

   sbs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign process    = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_data_ff <= req_data_type'(req_tdata[$bits(req_data_type)-1:0]);
         in_op_ff   <= op_type'(req_tuser);
      end
   end

   assign limit = (cfg.max_attempts > 5'(MAX_ATTEMPT_LIMIT)) ?
                  5'(MAX_ATTEMPT_LIMIT) : cfg.max_attempts;
   assign attempts_inc = attempts_ff + 5'd1;
   assign code         = reply_type'(in_data_ff.reply_code);

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         window[i] = (5'(i) <= attempts_ff);
      end
   end

   assign pick         = in_data_ff.random_bits & window;
   assign product      = {16'b0, pick} * {16'b0, cfg.slot_time};
   assign product_zero = (pick == 16'd0) || (cfg.slot_time == 16'd0);

   always_comb begin
      phase_in     = phase_ff;
      attempts_in  = attempts_ff;
      wait_left_in = wait_left_ff;
      action       = ACT_NONE;
      loaded       = '0;
      unique case (in_op_ff)
         OP_START: begin
            attempts_in  = '0;
            wait_left_in = '0;
            if (limit == 5'd0) begin
               phase_in = PH_IDLE;
               action   = ACT_GAVE_UP;
            end else begin
               phase_in = PH_SENSE;
               action   = ACT_SENSE;
            end
         end
         OP_REPLY: begin
            if (phase_ff == PH_SENSE || phase_ff == PH_REQ || phase_ff == PH_DONE) begin
               priority if (code == RC_CLOSED) begin
                  phase_in     = PH_IDLE;
                  wait_left_in = '0;
                  action       = ACT_CLOSED;
               end else if (phase_ff == PH_SENSE && code == RC_IDLE) begin
                  phase_in = PH_REQ;
                  action   = ACT_REQUEST;
               end else if (phase_ff == PH_SENSE && code == RC_BUSY) begin
                  loaded = {16'b0, cfg.slot_time};
                  if (cfg.slot_time == 16'd0) begin
                     wait_left_in = '0;
                     if (attempts_ff >= limit) begin
                        phase_in = PH_IDLE;
                        action   = ACT_GAVE_UP;
                     end else begin
                        phase_in = PH_SENSE;
                        action   = ACT_SENSE;
                     end
                  end else begin
                     wait_left_in = {16'b0, cfg.slot_time};
                     phase_in     = PH_HOLD;
                  end
               end else if (phase_ff == PH_REQ && code == RC_HUH) begin
                  attempts_in = attempts_inc;
                  loaded      = product;
                  if (product_zero) begin
                     wait_left_in = '0;
                     if (attempts_inc >= limit) begin
                        phase_in = PH_IDLE;
                        action   = ACT_GAVE_UP;
                     end else begin
                        phase_in = PH_SENSE;
                        action   = ACT_SENSE;
                     end
                  end else begin
                     wait_left_in = product;
                     phase_in     = PH_HOLD;
                  end
               end else if (phase_ff == PH_REQ && code == RC_OK) begin
                  phase_in = PH_DONE;
               end else if (phase_ff == PH_DONE && code == RC_DONE) begin
                  phase_in = PH_IDLE;
                  action   = ACT_SUCCESS;
               end else begin
                  phase_in = PH_SENSE;
                  action   = ACT_SENSE;
               end
            end
         end
         OP_TICK: begin
            if (phase_ff == PH_HOLD) begin
               if (wait_left_ff > 32'd1) begin
                  wait_left_in = wait_left_ff - 32'd1;
               end else begin
                  wait_left_in = '0;
                  if (attempts_ff >= limit) begin
                     phase_in = PH_IDLE;
                     action   = ACT_GAVE_UP;
                  end else begin
                     phase_in = PH_SENSE;
                     action   = ACT_SENSE;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   assign rsp_data_in.wait_loaded   = loaded;
   assign rsp_data_in.attempt_count = attempts_in;
   assign rsp_data_in.action        = action;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         attempts_ff  <= '0;
         wait_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (process) begin
            phase_ff     <= phase_in;
            attempts_ff  <= attempts_in;
            wait_left_ff <= wait_left_in;
         end
         if (advance) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (process) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_HOLD) == (wait_left_ff != 32'd0))
      else $error("hold phase and remaining wait disagree");

   assert property (@(posedge clock) disable iff (reset)
      attempts_ff <= 5'(MAX_ATTEMPT_LIMIT))
      else $error("collision count beyond limit");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.wait_loaded != 32'd0 && rsp_data_ff.action != ACT_NONE)
      |-> (rsp_data_ff.action == ACT_SENSE || rsp_data_ff.action == ACT_GAVE_UP) &&
          (rsp_data_ff.wait_loaded[31:16] == 16'd0))
      else $error("non-zero hold with unexpected action");
`endif

endmodule

`default_nettype wire
